[hdl/rme_pkg.sv]
package rme_pkg;

  // Fixed field and port widths
  localparam int DATA_WIDTH     = 32;
  localparam int HALF_WIDTH     = 16;
  localparam int CFG_ADDR_WIDTH = 5;
  localparam int CFG_DATA_WIDTH = 64;

  // Register indexes, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_MODULUS   = 2'd0,
    REG_PUB_EXP   = 2'd1,
    REG_PRIV_EXP  = 2'd2,
    REG_DIRECTION = 2'd3
  } reg_idx_t;

  // Exponentiation sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } state_t;

  // Status of the modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

[hdl/rme_cfg.sv]
module rme_cfg #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rme_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  logic [rme_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [rme_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready,
  output logic [MOD_WIDTH-1:0]                 modulus,
  output logic [EXP_WIDTH-1:0]                 public_exponent,
  output logic [EXP_WIDTH-1:0]                 private_exponent,
  output logic                                 direction
);

  localparam int DW = rme_pkg::CFG_DATA_WIDTH;

  logic [MOD_WIDTH-1:0] modulus_r;
  logic [EXP_WIDTH-1:0] pub_exp_r;
  logic [EXP_WIDTH-1:0] priv_exp_r;
  logic                 dir_r;
  logic                 wr_en;
  rme_pkg::reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = rme_pkg::reg_idx_t'(paddr[4:3]);

  // Write registers on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= '0;
      pub_exp_r  <= '0;
      priv_exp_r <= '0;
      dir_r      <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        rme_pkg::REG_MODULUS:   modulus_r  <= pwdata[MOD_WIDTH-1:0];
        rme_pkg::REG_PUB_EXP:   pub_exp_r  <= pwdata[EXP_WIDTH-1:0];
        rme_pkg::REG_PRIV_EXP:  priv_exp_r <= pwdata[EXP_WIDTH-1:0];
        rme_pkg::REG_DIRECTION: dir_r      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      rme_pkg::REG_MODULUS:   prdata = DW'(modulus_r);
      rme_pkg::REG_PUB_EXP:   prdata = DW'(pub_exp_r);
      rme_pkg::REG_PRIV_EXP:  prdata = DW'(priv_exp_r);
      rme_pkg::REG_DIRECTION: prdata = DW'(dir_r);
      default:                prdata = '0;
    endcase
  end

  assign modulus          = modulus_r;
  assign public_exponent  = pub_exp_r;
  assign private_exponent = priv_exp_r;
  assign direction        = dir_r;

endmodule

[hdl/rme_modmul.sv]
module rme_modmul #(
  parameter int MOD_WIDTH = 32,
  parameter int Y_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MOD_WIDTH-1:0]  x,
  input  logic [Y_WIDTH-1:0]    y,
  input  logic [MOD_WIDTH-1:0]  m,
  output logic [MOD_WIDTH-1:0]  p,
  output rme_pkg::mm_stat_t     stat
);

  localparam int CW = $clog2(Y_WIDTH + 1);

  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;
  logic [MOD_WIDTH-1:0] x_r;
  logic [Y_WIDTH-1:0]   y_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   sum_red;
  logic [MOD_WIDTH:0]   m_ext;

  // One multiplier bit per cycle while busy: double, reduce, add x if the bit is set, reduce
  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]} + {1'b0, x_r};
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    acc_nxt = y_r[Y_WIDTH-1] ? sum_red[MOD_WIDTH-1:0] : dbl_red[MOD_WIDTH-1:0];
  end

  // Control: bit counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(Y_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulator and multiplier shift register
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      y_r   <= y;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[Y_WIDTH-2:0], 1'b0};
    end
  end

  assign p         = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // Accumulator stays reduced while a product is formed
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (acc_r < m))
    else $error("modmul accumulator not below modulus");

  // A new product is never started over a running one
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("modmul started while busy");

endmodule

[hdl/rsa_modular_exponentiation.sv]
// Sequence: the base is reduced, then each of the EXP_WIDTH exponent bits takes a square
// and, where the bit is set, a multiply, each a shift-and-add modular product over a
// max(MOD_WIDTH, 32)-bit multiplier operand; a zero modulus skips the multiplier.
// Throughput: one transaction at a time through the single modular multiplier; the next
// input is taken while a finished result waits in the output register.
// Reset: synchronous active-low rst_n clears config registers to zero and empties the block.
module rsa_modular_exponentiation #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rme_pkg::DATA_WIDTH-1:0]      in_data_in,
  input  logic                                in_last_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rme_pkg::DATA_WIDTH-1:0]      out_data_out,
  output logic                                out_last_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rme_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [rme_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [rme_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  localparam int DW  = rme_pkg::DATA_WIDTH;
  localparam int HW  = rme_pkg::HALF_WIDTH;
  localparam int RW  = (MOD_WIDTH > DW) ? MOD_WIDTH : DW;
  localparam int ECW = $clog2(EXP_WIDTH + 1);

  logic [MOD_WIDTH-1:0] cfg_modulus;
  logic [EXP_WIDTH-1:0] cfg_pub_exp;
  logic [EXP_WIDTH-1:0] cfg_priv_exp;
  logic                 cfg_dir;

  rme_pkg::state_t      state_r, state_nxt;
  logic [MOD_WIDTH-1:0] m_r, m_nxt;
  logic [MOD_WIDTH-1:0] one_val;
  logic [DW-1:0]        word_in;
  logic [DW-1:0]        word_r, word_nxt;
  logic [EXP_WIDTH-1:0] exp_r, exp_nxt;
  logic [ECW-1:0]       cnt_r, cnt_nxt;
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;
  logic [MOD_WIDTH-1:0] base_r, base_nxt;
  logic [RW-1:0]        res_r, res_nxt;
  logic                 dir_r, dir_nxt;
  logic                 last_r, last_nxt;
  logic                 mul_start_r, mul_start_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DW-1:0]        out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [MOD_WIDTH-1:0] mul_x;
  logic [RW-1:0]        mul_y;
  logic [MOD_WIDTH-1:0] mul_p;
  logic                 out_free;
  rme_pkg::mm_stat_t    mm_stat;

  rme_cfg #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .modulus          (cfg_modulus),
    .public_exponent  (cfg_pub_exp),
    .private_exponent (cfg_priv_exp),
    .direction        (cfg_dir)
  );

  rme_modmul #(
    .MOD_WIDTH (MOD_WIDTH),
    .Y_WIDTH   (RW)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .x     (mul_x),
    .y     (mul_y),
    .m     (m_r),
    .p     (mul_p),
    .stat  (mm_stat)
  );

  // Input word, cut to 16 bits when encrypting
  assign word_in  = cfg_dir ? in_data_in : {{(DW-HW){1'b0}}, in_data_in[HW-1:0]};
  assign one_val  = (m_r == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  assign in_stall = (state_r != rme_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Select multiplier operands for the current step
  always_comb begin
    case (state_r)
      rme_pkg::ST_REDUCE: begin
        mul_x = one_val;
        mul_y = RW'(word_r);
      end
      rme_pkg::ST_MULT: begin
        mul_x = base_r;
        mul_y = RW'(acc_r);
      end
      default: begin
        mul_x = acc_r;
        mul_y = RW'(acc_r);
      end
    endcase
  end

  // Sequence: reduce base, then square and multiply over the exponent bits; a zero modulus goes straight to done
  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    word_nxt      = word_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    dir_nxt       = dir_r;
    last_nxt      = last_r;
    mul_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      rme_pkg::ST_IDLE: begin
        if (in_valid) begin
          m_nxt    = cfg_modulus;
          word_nxt = word_in;
          dir_nxt  = cfg_dir;
          last_nxt = in_last_in;
          exp_nxt  = cfg_dir ? cfg_priv_exp : cfg_pub_exp;
          if (cfg_modulus == '0) begin
            res_nxt   = RW'(word_in);
            state_nxt = rme_pkg::ST_DONE;
          end else begin
            mul_start_nxt = 1'b1;
            state_nxt     = rme_pkg::ST_REDUCE;
          end
        end
      end
      rme_pkg::ST_REDUCE: begin
        if (mm_stat.done) begin
          base_nxt      = mul_p;
          acc_nxt       = one_val;
          cnt_nxt       = ECW'(EXP_WIDTH);
          mul_start_nxt = 1'b1;
          state_nxt     = rme_pkg::ST_SQUARE;
        end
      end
      rme_pkg::ST_SQUARE: begin
        if (mm_stat.done) begin
          acc_nxt = mul_p;
          if (exp_r[EXP_WIDTH-1]) begin
            mul_start_nxt = 1'b1;
            state_nxt     = rme_pkg::ST_MULT;
          end else begin
            exp_nxt = {exp_r[EXP_WIDTH-2:0], 1'b0};
            cnt_nxt = cnt_r - ECW'(1);
            if (cnt_r == ECW'(1)) begin
              res_nxt   = RW'(mul_p);
              state_nxt = rme_pkg::ST_DONE;
            end else begin
              mul_start_nxt = 1'b1;
            end
          end
        end
      end
      rme_pkg::ST_MULT: begin
        if (mm_stat.done) begin
          acc_nxt = mul_p;
          exp_nxt = {exp_r[EXP_WIDTH-2:0], 1'b0};
          cnt_nxt = cnt_r - ECW'(1);
          if (cnt_r == ECW'(1)) begin
            res_nxt   = RW'(mul_p);
            state_nxt = rme_pkg::ST_DONE;
          end else begin
            mul_start_nxt = 1'b1;
            state_nxt     = rme_pkg::ST_SQUARE;
          end
        end
      end
      rme_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_r;
          out_data_nxt  = dir_r ? {{(DW-HW){1'b0}}, res_r[HW-1:0]} : res_r[DW-1:0];
          state_nxt     = rme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rme_pkg::ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rme_pkg::ST_IDLE;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_start_r <= mul_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    word_r     <= word_nxt;
    exp_r      <= exp_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    res_r      <= res_nxt;
    dir_r      <= dir_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_last_out = out_last_r;

  // Multiplier finishes only during an exponentiation step
  a_done_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |-> (state_r == rme_pkg::ST_REDUCE || state_r == rme_pkg::ST_SQUARE ||
                      state_r == rme_pkg::ST_MULT))
    else $error("multiplier done outside an exponentiation step");

  // A finished result waits while the output register is blocked
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rme_pkg::ST_DONE && out_valid_r && out_stall) |=>
      (state_r == rme_pkg::ST_DONE))
    else $error("result left while output register blocked");

  // Decrypt results carry only the low half word
  a_decrypt_cut: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rme_pkg::ST_DONE && dir_r && out_free) |=>
      (out_data_r[DW-1:HW] == '0))
    else $error("decrypt result has upper bits set");

endmodule
